// File: rtl/ilsf_pkg.sv
// ilsf_pkg: shared sizes, codes, request and result types and coordinate tables
// for the ising lattice spin-flip block; depends on nothing
`default_nettype none

package ilsf_pkg;

  // lattice geometry
  localparam int SIDE_X = 64;
  localparam int SIDE_Y = 64;
  localparam int XW     = $clog2(SIDE_X);
  localparam int YW     = $clog2(SIDE_Y);

  // fixed field widths
  localparam int CRD_W     = 6;
  localparam int CRD_N     = 2 ** CRD_W;
  localparam int RND_W     = 32;
  localparam int THR_W     = 33;
  localparam int CFG_IDX_W = 2;

  // request kinds, the unused code behaves as a read
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 2'd1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CRD_W-1:0] site_x;
    logic [CRD_W-1:0] site_y;
    logic [RND_W-1:0] random_word;
    logic             new_spin;
  } in_t;

  typedef struct packed {
    logic              spin_after;
    logic              flipped;
    logic signed [3:0] local_product;
  } out_t;

  // request after coordinate reduction
  typedef struct packed {
    logic [1:0]       kind;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [RND_W-1:0] rnd;
    logic             new_spin;
  } req_t;

  typedef struct packed {
    logic [THR_W-1:0] two;
    logic [THR_W-1:0] four;
  } thr_t;

  // evaluation outcome: write-back row and result
  typedef struct packed {
    logic              wr_en;
    logic [SIDE_Y-1:0] row;
    out_t              res;
  } eval_t;

  // coordinate reduction tables, built at elaboration
  typedef logic [CRD_N-1:0][XW-1:0] xmod_tbl_t;
  typedef logic [CRD_N-1:0][YW-1:0] ymod_tbl_t;

  function automatic xmod_tbl_t build_xmod();
    xmod_tbl_t t;
    for (int i = 0; i < CRD_N; i++) begin
      t[i] = XW'(i % SIDE_X);
    end
    return t;
  endfunction

  function automatic ymod_tbl_t build_ymod();
    ymod_tbl_t t;
    for (int i = 0; i < CRD_N; i++) begin
      t[i] = YW'(i % SIDE_Y);
    end
    return t;
  endfunction

  localparam xmod_tbl_t XMOD_TBL = build_xmod();
  localparam ymod_tbl_t YMOD_TBL = build_ymod();

endpackage

`default_nettype wire

// File: rtl/ilsf_ram.sv
// ilsf_ram: generic synchronous ram, one write port and two registered read ports
// read during write to the same address returns the new data; no dependencies
`default_nettype none

module ilsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ilsf_site_eval.sv
// ilsf_site_eval: neighbour sum, local product, acceptance test and row update
// for one request; depends on ilsf_pkg
`default_nettype none

module ilsf_site_eval (
  input  wire logic [ilsf_pkg::SIDE_Y-1:0] row_i,
  input  wire ilsf_pkg::req_t              req,
  input  wire logic                        nb_up,
  input  wire logic                        nb_dn,
  input  wire ilsf_pkg::thr_t              thr,
  output ilsf_pkg::eval_t                  ev
);

  logic [ilsf_pkg::YW-1:0] ym;
  logic [ilsf_pkg::YW-1:0] yp;
  logic                    spin;
  logic [2:0]              ones;
  logic signed [3:0]       sum;
  logic signed [3:0]       prod;
  logic                    accept;

  assign ym = (req.y == '0) ? ilsf_pkg::YW'(ilsf_pkg::SIDE_Y - 1)
                            : req.y - ilsf_pkg::YW'(1);
  assign yp = (req.y == ilsf_pkg::YW'(ilsf_pkg::SIDE_Y - 1)) ? '0
                            : req.y + ilsf_pkg::YW'(1);

  assign spin = row_i[req.y];
  assign ones = {2'b00, nb_up} + {2'b00, nb_dn} + {2'b00, row_i[ym]} + {2'b00, row_i[yp]};
  // sum of four +-1 values is 2*ones - 4
  assign sum  = $signed({ones, 1'b0}) - 4'sd4;
  assign prod = spin ? sum : 4'sd0 - sum;

  always_comb begin
    if (prod <= 4'sd0) begin
      accept = 1'b1;
    end else if (prod == 4'sd2) begin
      accept = {1'b0, req.rnd} < thr.two;
    end else begin
      accept = {1'b0, req.rnd} < thr.four;
    end
  end

  always_comb begin
    ev.row               = row_i;
    ev.wr_en             = 1'b0;
    ev.res.flipped       = 1'b0;
    ev.res.local_product = 4'sd0;
    unique case (req.kind)
      ilsf_pkg::KIND_UPDATE: begin
        ev.res.local_product = prod;
        if (accept) begin
          ev.row[req.y]  = ~spin;
          ev.wr_en       = 1'b1;
          ev.res.flipped = 1'b1;
        end
      end
      ilsf_pkg::KIND_WRITE: begin
        ev.row[req.y] = req.new_spin;
        ev.wr_en      = 1'b1;
      end
      default: begin
      end
    endcase
    ev.res.spin_after = ev.row[req.y];
  end

endmodule

`default_nettype wire

// File: rtl/ising_lattice_spin_flip.sv
// ising_lattice_spin_flip: periodic 2d ising lattice with metropolis single-spin trials
// the result is registered as the request retires from S_EXEC, after the S_ROW state
// a request is taken in S_IDLE or as the last one retires, set by the row reads on the two-port ram
//   (neighbour rows above and below first, then the site row, then write-back)
// reset is synchronous; a clearing pass fills every row with +1,
//   no request is taken during it; thresholds reset to zero
// depends on ilsf_pkg, ilsf_ram, ilsf_site_eval
`default_nettype none

module ising_lattice_spin_flip (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ilsf_pkg::in_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ilsf_pkg::out_t                       out_data,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ilsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ilsf_pkg::THR_W-1:0]      cfg_wdata
);

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,  // clearing pass after reset
    S_IDLE  = 4'b0010,  // waiting for a request
    S_ROW   = 4'b0100,  // neighbour rows arrive, site row is read
    S_EXEC  = 4'b1000   // site row arrives, evaluate and write back
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ilsf_pkg::XW-1:0]   clr_cnt_r, clr_cnt_nxt;
  ilsf_pkg::req_t            req_r;
  logic                      nb_up_r;
  logic                      nb_dn_r;
  ilsf_pkg::thr_t            thr_r;
  logic                      out_valid_r, out_valid_nxt;
  ilsf_pkg::out_t            out_data_r;

  // request decode
  ilsf_pkg::req_t            in_req;
  logic [ilsf_pkg::XW-1:0]   in_xm;
  logic [ilsf_pkg::XW-1:0]   in_xp;
  logic                      in_acc;
  logic                      out_free;
  logic                      exec_fire;

  // ram ports
  logic                          ram_we;
  logic [ilsf_pkg::XW-1:0]       ram_waddr;
  logic [ilsf_pkg::SIDE_Y-1:0]   ram_wdata;
  logic                          ram_re_a;
  logic [ilsf_pkg::XW-1:0]       ram_raddr_a;
  logic [ilsf_pkg::SIDE_Y-1:0]   ram_rdata_a;
  logic                          ram_re_b;
  logic [ilsf_pkg::SIDE_Y-1:0]   ram_rdata_b;

  ilsf_pkg::eval_t           ev;

  // coordinates reduced modulo the lattice sides through constant tables
  always_comb begin
    in_req.kind     = in_data.kind;
    in_req.x        = ilsf_pkg::XMOD_TBL[in_data.site_x];
    in_req.y        = ilsf_pkg::YMOD_TBL[in_data.site_y];
    in_req.rnd      = in_data.random_word;
    in_req.new_spin = in_data.new_spin;
  end

  // wrapped rows above and below
  assign in_xm = (in_req.x == '0) ? ilsf_pkg::XW'(ilsf_pkg::SIDE_X - 1)
                                  : in_req.x - ilsf_pkg::XW'(1);
  assign in_xp = (in_req.x == ilsf_pkg::XW'(ilsf_pkg::SIDE_X - 1)) ? '0
                                  : in_req.x + ilsf_pkg::XW'(1);

  // result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = (state_r == S_EXEC) && out_free;
  // a new request may enter while the previous one retires
  assign in_stall  = !((state_r == S_IDLE) || exec_fire);
  assign in_acc    = in_valid && !in_stall;

  // ram control: neighbour rows on both ports at accept, site row on port a
  always_comb begin
    ram_re_a    = 1'b0;
    ram_re_b    = 1'b0;
    ram_raddr_a = in_xm;
    ram_we      = 1'b0;
    ram_waddr   = req_r.x;
    ram_wdata   = ev.row;
    if (in_acc) begin
      ram_re_a = 1'b1;
      ram_re_b = 1'b1;
    end
    if (state_r == S_ROW) begin
      ram_re_a    = 1'b1;
      ram_raddr_a = req_r.x;
    end
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '1;
    end else if (exec_fire) begin
      // a neighbour read of the next request in the same cycle sees this write
      ram_we = ev.wr_en;
    end
  end

  ilsf_ram #(
    .WIDTH (ilsf_pkg::SIDE_Y),
    .DEPTH (ilsf_pkg::SIDE_X)
  ) u_lattice (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (in_xp),
    .rdata_b (ram_rdata_b)
  );

  ilsf_site_eval u_eval (
    .row_i (ram_rdata_a),
    .req   (req_r),
    .nb_up (nb_up_r),
    .nb_dn (nb_dn_r),
    .thr   (thr_r),
    .ev    (ev)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ilsf_pkg::XW'(1);
        if (clr_cnt_r == ilsf_pkg::XW'(ilsf_pkg::SIDE_X - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = in_acc ? S_ROW : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == ilsf_pkg::CFG_THR_TWO)) begin
        thr_r.two <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == ilsf_pkg::CFG_THR_FOUR)) begin
        thr_r.four <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req;
    end
    // pick the site column out of the neighbour rows
    if (state_r == S_ROW) begin
      nb_up_r <= ram_rdata_a[req_r.y];
      nb_dn_r <= ram_rdata_b[req_r.y];
    end
    if (exec_fire) begin
      out_data_r <= ev.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no request is taken while the lattice is being cleared
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  // an accepted request always goes on to its row read
  a_acc_to_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ROW))
    else $error("accepted request did not start its row read");

  // a waiting result is never overwritten: evaluation holds
  a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && out_valid_r && out_stall) |=>
      ((state_r == S_EXEC) && out_valid_r && $stable(out_data_r)))
    else $error("result overwritten while stalled");

  // the lattice is only written by the clearing pass or a retiring request
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_CLEAR) || exec_fire))
    else $error("lattice write outside clearing or retire");

endmodule

`default_nettype wire

// File: test/tb.sv
// tb: self-checking bench for ising_lattice_spin_flip, site access, flip decisions,
// threshold settings, back-pressure and long random mixes against a lattice copy
// depends on ilsf_pkg and the ising_lattice_spin_flip rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [1:0]                     KIND_SPARE   = 2'd3;
  localparam logic [ilsf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ilsf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [ilsf_pkg::THR_W-1:0] THR_ONE = 33'h1_0000_0000; // accepts every word
  localparam int                         STALL_LIMIT = 4000;
  localparam int                         HOLD_CYCLES = 300;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  ilsf_pkg::in_t                  in_data;
  logic                           out_valid;
  logic                           out_stall;
  ilsf_pkg::out_t                 out_data;
  logic                           cfg_we;
  logic [ilsf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ilsf_pkg::THR_W-1:0]     cfg_wdata;

  // lattice copy and threshold copies kept in step with accepted requests
  logic                       spin_copy [ilsf_pkg::SIDE_X][ilsf_pkg::SIDE_Y];
  logic [ilsf_pkg::THR_W-1:0] thr_two_copy;
  logic [ilsf_pkg::THR_W-1:0] thr_four_copy;
  ilsf_pkg::out_t             pending_results [$];

  int tx_idle_pct  = 28;
  int rx_idle_pct  = 58;
  int rx_hold_reqs = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  ising_lattice_spin_flip u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // spin of a site as +1 or -1
  function automatic int spin_of(int x, int y);
    return spin_copy[x][y] ? 1 : -1;
  endfunction

  // outcome of one request on the lattice copy, updating the copy as the block would
  function automatic ilsf_pkg::out_t trial_outcome(ilsf_pkg::in_t req);
    ilsf_pkg::out_t res;
    int   x, y, xm, xp, ym, yp, sum, prod;
    logic accept;
    x   = req.site_x % ilsf_pkg::SIDE_X;
    y   = req.site_y % ilsf_pkg::SIDE_Y;
    res = '0;
    case (req.kind)
      ilsf_pkg::KIND_UPDATE: begin
        // periodic wrap on all four neighbours
        xm   = (x + ilsf_pkg::SIDE_X - 1) % ilsf_pkg::SIDE_X;
        xp   = (x + 1) % ilsf_pkg::SIDE_X;
        ym   = (y + ilsf_pkg::SIDE_Y - 1) % ilsf_pkg::SIDE_Y;
        yp   = (y + 1) % ilsf_pkg::SIDE_Y;
        sum  = spin_of(xm, y) + spin_of(xp, y) + spin_of(x, ym) + spin_of(x, yp);
        prod = spin_of(x, y) * sum;
        if (prod <= 0) begin
          accept = 1'b1;
        end else if (prod == 2) begin
          accept = {1'b0, req.random_word} < thr_two_copy;
        end else begin
          accept = {1'b0, req.random_word} < thr_four_copy;
        end
        if (accept) begin
          spin_copy[x][y] = ~spin_copy[x][y];
        end
        res.flipped       = accept;
        res.local_product = 4'(prod);
      end
      ilsf_pkg::KIND_WRITE: begin
        spin_copy[x][y] = req.new_spin;
      end
      default: begin
        // read and the spare kind leave the lattice alone
      end
    endcase
    res.spin_after = spin_copy[x][y];
    return res;
  endfunction

  function automatic ilsf_pkg::in_t make_req(logic [1:0] kind, logic [5:0] x,
                                             logic [5:0] y, logic [31:0] rnd, logic ns);
    ilsf_pkg::in_t r;
    r.kind        = kind;
    r.site_x      = x;
    r.site_y      = y;
    r.random_word = rnd;
    r.new_spin    = ns;
    return r;
  endfunction

  // mostly requests clustered in a 4x4 window so neighbourhoods get mixed spins
  function automatic ilsf_pkg::in_t random_req(logic [5:0] bx, logic [5:0] by);
    ilsf_pkg::in_t r;
    int            pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.kind = ilsf_pkg::KIND_UPDATE;
    end else if (pick < 82) begin
      r.kind = ilsf_pkg::KIND_WRITE;
    end else if (pick < 95) begin
      r.kind = ilsf_pkg::KIND_READ;
    end else begin
      r.kind = KIND_SPARE;
    end
    if ($urandom_range(9) < 8) begin
      r.site_x = 6'(bx + $urandom_range(3));
      r.site_y = 6'(by + $urandom_range(3));
    end else begin
      r.site_x = 6'($urandom());
      r.site_y = 6'($urandom());
    end
    case ($urandom_range(7))
      0:       r.random_word = '0;
      1:       r.random_word = '1;
      default: r.random_word = $urandom();
    endcase
    r.new_spin = 1'($urandom_range(1));
    return r;
  endfunction

  // offer one request, with random idle cycles first, and predict it once taken
  task automatic offer_request(input ilsf_pkg::in_t req);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(trial_outcome(req));
  endtask

  // stop offering and let every outstanding result come back
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ilsf_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [ilsf_pkg::THR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      ilsf_pkg::CFG_THR_TWO:  thr_two_copy  = value;
      ilsf_pkg::CFG_THR_FOUR: thr_four_copy = value;
      default: ; // indexes past the list are ignored
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always begin
    @(negedge clk);
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic signed [4:0] want,
                             input logic signed [4:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // each result taken is held against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result expected none actual %b/%b/%0d", $time,
                 out_data.spin_after, out_data.flipped, out_data.local_product);
      end else begin
        ilsf_pkg::out_t want;
        want = pending_results.pop_front();
        check_field("spin_after", 5'(want.spin_after), 5'(out_data.spin_after));
        check_field("flipped", 5'(want.flipped), 5'(out_data.flipped));
        check_field("local_product", 5'(want.local_product),
                    5'(out_data.local_product));
      end
    end
  end

  // watchdog: too long with no request, result or register write taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reads, writes and the spare kind at the lattice corners, with reset thresholds
  task automatic test_site_access();
    offer_request(make_req(ilsf_pkg::KIND_READ,   6'd0,  6'd0,  32'hFFFF_FFFF, 1'b1));
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd63, 6'd63, 32'hFFFF_FFFF, 1'b0));
    offer_request(make_req(ilsf_pkg::KIND_READ,   6'd63, 6'd63, 32'h0,         1'b1));
    offer_request(make_req(KIND_SPARE,            6'd63, 6'd63, 32'h0,         1'b1));
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd0,  6'd63, 32'h0,         1'b1));
    // aligned neighbourhood, threshold zero rejects even a zero word
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd0,  6'd0,  32'h0,         1'b0));
    // lone down spin among up neighbours always flips
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1));
  endtask

  // walk one site through products of +2, -2 and zero, then try +4 at another site
  task automatic test_flip_products();
    quiesce();
    write_threshold(ilsf_pkg::CFG_THR_TWO, THR_ONE);
    write_threshold(ilsf_pkg::CFG_THR_FOUR, '0);
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd10, 6'd11, 32'h0,         1'b0));
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd10, 6'd10, 32'hFFFF_FFFF, 1'b0)); // +2
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd10, 6'd10, 32'hFFFF_FFFF, 1'b1)); // -2
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd9,  6'd10, 32'h0,         1'b0));
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd10, 6'd10, 32'h0,         1'b0)); // zero
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd10, 6'd10, 32'h0,         1'b1)); // zero
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd11, 6'd10, 32'h0,         1'b0));
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd10, 6'd10, 32'h0,         1'b0)); // -2
    quiesce();
    write_threshold(ilsf_pkg::CFG_THR_TWO, '0);
    write_threshold(ilsf_pkg::CFG_THR_FOUR, THR_ONE);
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd20, 6'd20, 32'hFFFF_FFFF, 1'b0)); // +4
  endtask

  // thresholds at their edges and writes to indexes past the register list
  task automatic test_threshold_edges();
    quiesce();
    write_threshold(CFG_SPARE_LO, '1);
    write_threshold(CFG_SPARE_HI, '0);
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd30, 6'd30, 32'hFFFF_FFFF, 1'b0));
    quiesce();
    write_threshold(ilsf_pkg::CFG_THR_FOUR, 33'd1);
    write_threshold(ilsf_pkg::CFG_THR_TWO, 33'h0_FFFF_FFFF);
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd40, 6'd40, 32'h0,         1'b0));
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd41, 6'd41, 32'h1,         1'b0));
    offer_request(make_req(ilsf_pkg::KIND_WRITE,  6'd50, 6'd51, 32'h0,         1'b0));
    // word equal to the threshold is rejected, one below accepted
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd50, 6'd50, 32'hFFFF_FFFF, 1'b0));
    offer_request(make_req(ilsf_pkg::KIND_UPDATE, 6'd50, 6'd50, 32'hFFFF_FFFE, 1'b0));
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    logic [5:0] bx, by;
    quiesce();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    bx           = 6'($urandom());
    by           = 6'($urandom());
    rx_hold_reqs = rx_hold_reqs + 1;
    for (int i = 0; i < 40; i++) begin
      offer_request(random_req(bx, by));
    end
  endtask

  task automatic run_random_phase(input int count, input int snd_pct, input int rcv_pct,
                                  input logic [ilsf_pkg::THR_W-1:0] t2,
                                  input logic [ilsf_pkg::THR_W-1:0] t4);
    logic [5:0] bx, by;
    quiesce();
    write_threshold(ilsf_pkg::CFG_THR_TWO, t2);
    write_threshold(ilsf_pkg::CFG_THR_FOUR, t4);
    tx_idle_pct = snd_pct;
    rx_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++) begin
      // move the window now and then, corners included
      if (i % 32 == 0) begin
        bx = 6'($urandom());
        by = 6'($urandom());
      end
      offer_request(random_req(bx, by));
    end
  endtask

  // three idle patterns, two threshold settings under each
  task automatic test_random_mix();
    run_random_phase(150, 28, 58, {1'b0, $urandom()}, {1'b0, $urandom()});
    run_random_phase(150, 28, 58, '0, THR_ONE);
    run_random_phase(150, 58, 28, THR_ONE, '0);
    run_random_phase(150, 58, 28, 33'd1, 33'h0_FFFF_FFFF);
    run_random_phase(150, 0, 0, {1'b0, $urandom()}, {1'b0, $urandom()});
    run_random_phase(150, 0, 0, THR_ONE, THR_ONE);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    thr_two_copy  = '0;
    thr_four_copy = '0;
    // every site starts at +1
    for (int x = 0; x < ilsf_pkg::SIDE_X; x++) begin
      for (int y = 0; y < ilsf_pkg::SIDE_Y; y++) begin
        spin_copy[x][y] = 1'b1;
      end
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // the clearing pass holds off requests until the lattice is filled
    do @(posedge clk); while (in_stall !== 1'b0);

    test_site_access();
    test_flip_products();
    test_threshold_edges();
    test_backpressure();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ilsf_pkg.sv
rtl/ilsf_ram.sv
rtl/ilsf_site_eval.sv
rtl/ising_lattice_spin_flip.sv
test/tb.sv
